### hdl/ctrm_pkg.sv
// ctrm_pkg: shared constants, types and helpers of the card table range marker
// used by every module under hdl; depends on nothing

package ctrm_pkg;

    // fixed field widths
    localparam int ADDR_W     = 32;
    localparam int HEAP_SIZE_W = 26;
    localparam int PCT_W      = 7;
    localparam int CNT_W      = 17;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // defaults of the top level parameters
    localparam int CARD_SHIFT_DEF = 9;
    localparam int MAX_CARDS_DEF  = 65536;

    // cards per memory row is 2**ROW_LOG2_MAX at most
    localparam int ROW_LOG2_MAX = 5;

    // depth of the queues between and behind the two halves
    localparam int QUEUE_DEPTH = 2;

    // dirty ratio is compared in percent
    localparam int PERCENT_SCALE = 100;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_PCT   = 2'd2;

    // input action codes
    localparam logic ACT_MARK  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] newly_dirtied;
        logic [CNT_W-1:0] dirty_count;
        logic             saturated;
        logic             saturation_event;
    } t_result;

    // counts saturate at the field maximum
    function automatic logic [CNT_W-1:0] clip_count(input logic [31:0] value);
        return (value > 32'(CNT_MAX)) ? CNT_MAX : value[CNT_W-1:0];
    endfunction

endpackage

### hdl/ctrm_fifo.sv
// ctrm_fifo: small first-in first-out queue of flip-flops
// depends on ctrm_pkg for the default depth

module ctrm_fifo
    import ctrm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [AW:0]      r_count, n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == (AW+1)'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_buf[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

endmodule

### hdl/ctrm_front.sv
// ctrm_front: takes requests, clamps the byte range to the heap, finds first and last card
// depends on ctrm_pkg; feeds the command queue in front of ctrm_back

module ctrm_front
    import ctrm_pkg::*;
#(
    parameter int CARD_SHIFT = CARD_SHIFT_DEF,
    parameter int MAX_CARDS  = MAX_CARDS_DEF,
    localparam int CW        = $clog2(MAX_CARDS),
    localparam int TCW       = $clog2(MAX_CARDS + 1),
    localparam int CMD_W     = 2 + 2 * CW
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_action,
    input  logic [ADDR_W-1:0]      i_range_start,
    input  logic [ADDR_W-1:0]      i_range_length,
    output logic                   o_stall,
    input  logic [ADDR_W-1:0]      i_heap_base,
    input  logic [HEAP_SIZE_W-1:0] i_heap_size,
    input  logic [TCW-1:0]         i_total_cards,
    input  logic                   i_cmd_full,
    output logic                   o_cmd_push,
    output logic [CMD_W-1:0]       o_cmd
);

    typedef struct packed {
        logic          clear;
        logic          none;
        logic [CW-1:0] first;
        logic [CW-1:0] last;
    } t_cmd;

    // stage one: captured request with its end address
    logic                   r1_valid, n1_valid;
    logic                   r1_clear;
    logic [ADDR_W-1:0]      r1_start;
    logic [ADDR_W:0]        r1_end;
    logic                   r1_len_zero;

    // stage two: offsets into the heap
    logic                   r2_valid, n2_valid;
    logic                   r2_clear;
    logic                   r2_none;
    logic [ADDR_W-1:0]      r2_first_off;
    logic [HEAP_SIZE_W-1:0] r2_end_off;

    logic                   w_adv1;
    logic                   w_adv2;
    logic                   w_s2_free;

    logic [ADDR_W:0]        w_end_off;
    logic [HEAP_SIZE_W-1:0] w_end_off_cl;
    logic [ADDR_W-1:0]      w_first_off;
    logic                   w_none1;

    logic [HEAP_SIZE_W-1:0] w_last_off;
    logic [ADDR_W-1:0]      w_first_idx;
    logic [HEAP_SIZE_W-1:0] w_last_idx;
    logic [TCW-1:0]         w_total_m1;
    t_cmd                   w_cmd;

    assign w_adv2    = r2_valid && !i_cmd_full;
    assign w_s2_free = !r2_valid || w_adv2;
    assign w_adv1    = r1_valid && w_s2_free;
    assign o_stall   = r1_valid && !w_s2_free;

    // stage one logic
    assign w_end_off    = r1_end - {1'b0, i_heap_base};
    assign w_end_off_cl = (w_end_off > (ADDR_W+1)'(i_heap_size)) ? i_heap_size
                                                                  : w_end_off[HEAP_SIZE_W-1:0];
    assign w_first_off  = (r1_start < i_heap_base) ? '0 : r1_start - i_heap_base;
    assign w_none1      = r1_len_zero || (i_heap_size == '0)
                          || (r1_end <= {1'b0, i_heap_base});

    // stage two logic
    assign w_last_off  = r2_end_off - 1'b1;
    assign w_first_idx = r2_first_off >> CARD_SHIFT;
    assign w_last_idx  = w_last_off >> CARD_SHIFT;
    assign w_total_m1  = i_total_cards - 1'b1;

    always_comb begin
        w_cmd.clear = r2_clear;
        w_cmd.none  = r2_none || (r2_first_off >= ADDR_W'(i_heap_size))
                      || (w_first_idx >= ADDR_W'(i_total_cards));
        w_cmd.first = CW'(w_first_idx);
        w_cmd.last  = (w_last_idx >= HEAP_SIZE_W'(i_total_cards)) ? CW'(w_total_m1)
                                                                   : CW'(w_last_idx);
    end

    assign o_cmd_push = w_adv2;
    assign o_cmd      = w_cmd;

    always_comb begin
        n1_valid = r1_valid;
        if (i_accept) begin
            n1_valid = 1'b1;
        end else if (w_adv1) begin
            n1_valid = 1'b0;
        end
        n2_valid = r2_valid;
        if (w_adv1) begin
            n2_valid = 1'b1;
        end else if (w_adv2) begin
            n2_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r1_valid <= n1_valid;
            r2_valid <= n2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r1_clear    <= (i_action == ACT_CLEAR);
            r1_start    <= i_range_start;
            r1_end      <= {1'b0, i_range_start} + {1'b0, i_range_length};
            r1_len_zero <= (i_range_length == '0);
        end
        if (w_adv1) begin
            r2_clear     <= r1_clear;
            r2_none      <= w_none1;
            r2_first_off <= w_first_off;
            r2_end_off   <= w_end_off_cl;
        end
    end

endmodule

### hdl/ctrm_back.sv
// ctrm_back: card memory, row sweep sequencer, dirty counter and saturation latch
// depends on ctrm_pkg; takes commands from ctrm_front through a ctrm_fifo

module ctrm_back
    import ctrm_pkg::*;
#(
    parameter int MAX_CARDS = MAX_CARDS_DEF,
    localparam int CW       = $clog2(MAX_CARDS),
    localparam int TCW      = $clog2(MAX_CARDS + 1),
    localparam int CMD_W    = 2 + 2 * CW
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_empty,
    input  logic [CMD_W-1:0] i_cmd,
    output logic             o_cmd_pop,
    input  logic [TCW-1:0]   i_total_cards,
    input  logic [PCT_W-1:0] i_sat_percent,
    input  logic             i_res_full,
    output logic             o_res_push,
    output t_result          o_res,
    output logic             o_booting
);

    typedef struct packed {
        logic          clear;
        logic          none;
        logic [CW-1:0] first;
        logic [CW-1:0] last;
    } t_cmd;

    typedef enum logic [6:0] {
        BK_BOOT   = 7'b0000001,
        BK_IDLE   = 7'b0000010,
        BK_CLEAR  = 7'b0000100,
        BK_READ   = 7'b0001000,
        BK_MODIFY = 7'b0010000,
        BK_PROD   = 7'b0100000,
        BK_REPORT = 7'b1000000
    } t_back_state;

    localparam int RL     = (CW < ROW_LOG2_MAX) ? CW : ROW_LOG2_MAX;
    localparam int W      = 1 << RL;
    localparam int ROWS   = (MAX_CARDS + W - 1) / W;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PROD_W = TCW + PCT_W;
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    logic [W-1:0]      r_mem [ROWS];
    logic [W-1:0]      r_rdata;

    t_back_state       r_state, n_state;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [ROW_W-1:0]  r_first_row, n_first_row;
    logic [ROW_W-1:0]  r_last_row, n_last_row;
    logic [RL-1:0]     r_first_lo, n_first_lo;
    logic [RL-1:0]     r_last_lo, n_last_lo;
    logic [TCW-1:0]    r_newly, n_newly;
    logic [TCW-1:0]    r_dirty, n_dirty;
    logic              r_latch, n_latch;
    logic [PROD_W-1:0] r_prod_dirty, n_prod_dirty;
    logic [PROD_W-1:0] r_prod_thresh, n_prod_thresh;

    t_cmd              w_cmd;
    logic              w_mem_we;
    logic              w_mem_re;
    logic [W-1:0]      w_wdata;
    logic [RL-1:0]     w_lo;
    logic [RL-1:0]     w_hi;
    logic [W-1:0]      w_mask;
    logic [W-1:0]      w_new_bits;
    logic [RL:0]       w_new_cnt;
    logic              w_sat;
    logic              w_event;

    assign w_cmd = i_cmd;

    // cards of the current row that fall inside the span
    always_comb begin
        w_lo = (r_row == r_first_row) ? r_first_lo : '0;
        w_hi = (r_row == r_last_row) ? r_last_lo : '1;
        for (int j = 0; j < W; j++) begin
            w_mask[j] = (RL'(j) >= w_lo) && (RL'(j) <= w_hi);
        end
    end

    assign w_new_bits = w_mask & ~r_rdata;
    assign w_new_cnt  = (RL+1)'($countones(w_new_bits));

    assign w_sat   = (i_total_cards != '0) && (r_prod_dirty >= r_prod_thresh);
    assign w_event = (r_newly != '0) && w_sat && !r_latch;

    assign o_res.newly_dirtied    = clip_count(32'(r_newly));
    assign o_res.dirty_count      = clip_count(32'(r_dirty));
    assign o_res.saturated        = w_sat;
    assign o_res.saturation_event = w_event;
    assign o_booting              = (r_state == BK_BOOT);

    always_comb begin
        n_state       = r_state;
        n_row         = r_row;
        n_first_row   = r_first_row;
        n_last_row    = r_last_row;
        n_first_lo    = r_first_lo;
        n_last_lo     = r_last_lo;
        n_newly       = r_newly;
        n_dirty       = r_dirty;
        n_latch       = r_latch;
        n_prod_dirty  = r_prod_dirty;
        n_prod_thresh = r_prod_thresh;
        w_mem_we      = 1'b0;
        w_mem_re      = 1'b0;
        w_wdata       = '0;
        o_cmd_pop     = 1'b0;
        o_res_push    = 1'b0;
        unique case (r_state)
            BK_BOOT: begin
                w_mem_we = 1'b1;
                if (r_row == ROW_LAST) begin
                    n_row   = '0;
                    n_state = BK_IDLE;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            BK_IDLE: begin
                if (!i_cmd_empty && !i_res_full) begin
                    o_cmd_pop   = 1'b1;
                    n_newly     = '0;
                    n_first_row = ROW_W'(w_cmd.first >> RL);
                    n_last_row  = ROW_W'(w_cmd.last >> RL);
                    n_first_lo  = w_cmd.first[RL-1:0];
                    n_last_lo   = w_cmd.last[RL-1:0];
                    if (w_cmd.clear) begin
                        n_row   = '0;
                        n_dirty = '0;
                        n_latch = 1'b0;
                        n_state = BK_CLEAR;
                    end else if (w_cmd.none) begin
                        n_state = BK_PROD;
                    end else begin
                        n_row   = ROW_W'(w_cmd.first >> RL);
                        n_state = BK_READ;
                    end
                end
            end
            BK_CLEAR: begin
                w_mem_we = 1'b1;
                if (r_row == ROW_LAST) begin
                    n_state = BK_PROD;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            BK_READ: begin
                w_mem_re = 1'b1;
                n_state  = BK_MODIFY;
            end
            BK_MODIFY: begin
                w_mem_we = 1'b1;
                w_wdata  = r_rdata | w_mask;
                n_newly  = r_newly + TCW'(w_new_cnt);
                n_dirty  = r_dirty + TCW'(w_new_cnt);
                if (r_row == r_last_row) begin
                    n_state = BK_PROD;
                end else begin
                    n_row   = r_row + 1'b1;
                    n_state = BK_READ;
                end
            end
            BK_PROD: begin
                n_prod_dirty  = PROD_W'(r_dirty) * PROD_W'(PERCENT_SCALE);
                n_prod_thresh = PROD_W'(i_total_cards) * PROD_W'(i_sat_percent);
                n_state       = BK_REPORT;
            end
            BK_REPORT: begin
                o_res_push = 1'b1;
                n_latch    = r_latch || w_event;
                n_state    = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_BOOT;
            r_row   <= '0;
            r_dirty <= '0;
            r_latch <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_dirty <= n_dirty;
            r_latch <= n_latch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_row   <= n_first_row;
        r_last_row    <= n_last_row;
        r_first_lo    <= n_first_lo;
        r_last_lo     <= n_last_lo;
        r_newly       <= n_newly;
        r_prod_dirty  <= n_prod_dirty;
        r_prod_thresh <= n_prod_thresh;
    end

    // one row of dirty bits per address
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_row] <= w_wdata;
        end
        if (w_mem_re) begin
            r_rdata <= r_mem[r_row];
        end
    end

endmodule

### hdl/card_table_range_marker_top.sv
// card_table_range_marker_top: configuration registers and the two halves joined by queues
// depends on ctrm_pkg, ctrm_fifo, ctrm_front and ctrm_back

// usage
//   requests enter through push/full: action, range_start, range_length; a request is
//   taken at an edge with push high and full low. results leave through empty/pop, one
//   per request in request order; the oldest result sits on the o_ ports while empty is low
//   and leaves at an edge with pop high
//   configuration writes (index, data) are taken whenever i_cfg_valid is high; only write
//   while no request is outstanding. register writes leave the cards untouched
// operation
//   the front captures a request in stage one, clamps it to the heap into stage two and
//   queues a command from there. the back takes the command, visits the span one memory row
//   of up to 32 cards at a time (read, then merge and count), forms the threshold products
//   and reports; a mark that touches no card goes straight to the threshold products
//   a clear request sweeps every row, one a cycle, before the products and the report
// reset and stalls
//   after reset the back sweeps the card memory clean, holding full high throughout. a
//   stalled receiver fills the result queue; the back then holds its next command, the
//   command queue and the front fill, and full rises

module card_table_range_marker_top
    import ctrm_pkg::*;
#(
    parameter int CARD_SHIFT = CARD_SHIFT_DEF,
    parameter int MAX_CARDS  = MAX_CARDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request side
    input  logic                 push,
    output logic                 full,
    input  logic                 i_action,
    input  logic [ADDR_W-1:0]    i_range_start,
    input  logic [ADDR_W-1:0]    i_range_length,
    // result side
    output logic                 empty,
    input  logic                 pop,
    output logic [CNT_W-1:0]     o_newly_dirtied,
    output logic [CNT_W-1:0]     o_dirty_count,
    output logic                 o_saturated,
    output logic                 o_saturation_event,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

    localparam int CW    = $clog2(MAX_CARDS);
    localparam int TCW   = $clog2(MAX_CARDS + 1);
    localparam int CMD_W = 2 + 2 * CW;

    // configuration registers
    logic [ADDR_W-1:0]      r_heap_base;
    logic [HEAP_SIZE_W-1:0] r_heap_size;
    logic [PCT_W-1:0]       r_sat_percent;

    logic [HEAP_SIZE_W:0]   w_size_round;
    logic [HEAP_SIZE_W:0]   w_cards;
    logic [TCW-1:0]         w_total_cards;

    logic                   w_accept;
    logic                   w_front_stall;
    logic                   w_booting;

    logic                   w_cmd_push;
    logic [CMD_W-1:0]       w_cmd_in;
    logic                   w_cmd_full;
    logic                   w_cmd_pop;
    logic [CMD_W-1:0]       w_cmd_out;
    logic                   w_cmd_empty;

    logic                   w_res_push;
    t_result                w_res_in;
    logic                   w_res_full;
    t_result                w_res_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base   <= '0;
            r_heap_size   <= '0;
            r_sat_percent <= PCT_W'(50);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEAP_BASE: r_heap_base   <= i_cfg_data;
                CFG_HEAP_SIZE: r_heap_size   <= i_cfg_data[HEAP_SIZE_W-1:0];
                CFG_SAT_PCT:   r_sat_percent <= i_cfg_data[PCT_W-1:0];
                default: begin
                    // index past the register list: write dropped
                end
            endcase
        end
    end

    // cards covering the heap, rounded up and capped at the table size
    assign w_size_round  = {1'b0, r_heap_size} + (HEAP_SIZE_W+1)'((1 << CARD_SHIFT) - 1);
    assign w_cards       = w_size_round >> CARD_SHIFT;
    assign w_total_cards = (w_cards > (HEAP_SIZE_W+1)'(MAX_CARDS)) ? TCW'(MAX_CARDS)
                                                                    : TCW'(w_cards);

    // no request enters while the front is blocked or the memory is still being swept
    assign full     = w_front_stall || w_booting;
    assign w_accept = push && !full;

    ctrm_front #(
        .CARD_SHIFT (CARD_SHIFT),
        .MAX_CARDS  (MAX_CARDS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_action       (i_action),
        .i_range_start  (i_range_start),
        .i_range_length (i_range_length),
        .o_stall        (w_front_stall),
        .i_heap_base    (r_heap_base),
        .i_heap_size    (r_heap_size),
        .i_total_cards  (w_total_cards),
        .i_cmd_full     (w_cmd_full),
        .o_cmd_push     (w_cmd_push),
        .o_cmd          (w_cmd_in)
    );

    // command queue: lets the front run ahead of a long sweep
    ctrm_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    ctrm_back #(
        .MAX_CARDS (MAX_CARDS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_empty   (w_cmd_empty),
        .i_cmd         (w_cmd_out),
        .o_cmd_pop     (w_cmd_pop),
        .i_total_cards (w_total_cards),
        .i_sat_percent (r_sat_percent),
        .i_res_full    (w_res_full),
        .o_res_push    (w_res_push),
        .o_res         (w_res_in),
        .o_booting     (w_booting)
    );

    // result queue: the back keeps working while the receiver stalls, until the queue is full
    ctrm_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_head),
        .o_empty (empty)
    );

    assign o_newly_dirtied    = w_res_head.newly_dirtied;
    assign o_dirty_count      = w_res_head.dirty_count;
    assign o_saturated        = w_res_head.saturated;
    assign o_saturation_event = w_res_head.saturation_event;

    // the back only reports when the result queue has room
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result pushed into a full queue");

    // commands are only taken from a non-empty queue
    a_cmd_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> !w_cmd_empty)
        else $error("command popped from an empty queue");

    // no request enters during the clearing sweep after reset
    a_boot_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_booting |-> full)
        else $error("request port open during memory sweep");

    // a reported crossing always comes with the saturated flag
    a_event_implies_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_push && w_res_in.saturation_event) |-> w_res_in.saturated)
        else $error("saturation event without saturation");

endmodule
